@@ rtl/core/md4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 package
// Shared item kinds, constants and round helpers for the MD4 engine.
// ----------------------------------------------------------------------------
package md4_pkg;

  typedef enum logic [1:0] {
    KIND_ABSORB  = 2'd0,
    KIND_FINISH  = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  localparam logic [31:0] IV_A     = 32'h67452301;
  localparam logic [31:0] IV_B     = 32'hefcdab89;
  localparam logic [31:0] IV_C     = 32'h98badcfe;
  localparam logic [31:0] IV_D     = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  // message word selected at step i (0..47)
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] j;
    begin
      j = i[3:0];
      case (i[5:4])
        2'd0:    word_sel = j;
        2'd1:    word_sel = {j[1:0], j[3:2]};
        default: word_sel = {j[0], j[1], j[2], j[3]};
      endcase
    end
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r;
    begin
      r = 5'd3;
      case ({i[5:4], i[1:0]})
        4'b0000, 4'b0100, 4'b1000: r = 5'd3;
        4'b0001: r = 5'd7;
        4'b0010: r = 5'd11;
        4'b0011: r = 5'd19;
        4'b0101: r = 5'd5;
        4'b0110: r = 5'd9;
        4'b0111: r = 5'd13;
        4'b1001: r = 5'd9;
        4'b1010: r = 5'd11;
        4'b1011: r = 5'd15;
        default: r = 5'd3;
      endcase
      rot_amt = r;
    end
  endfunction

endpackage

@@ rtl/core/md4_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 stream interfaces
// Valid/ready channels for input items and digest items.
// ----------------------------------------------------------------------------
interface md4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

@@ rtl/core/md4_hash_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD4 hash engine
// Byte-serial MD4: block buffer in a word memory, one compression step a cycle.
// ----------------------------------------------------------------------------
// Operation:
//   absorb byte: taken while idle; the 64th byte of a block starts 48 steps,
//   one per cycle, bound by the single read port of the block memory, then a fold.
//   finish: for each of one or two padded blocks, 16 padding writes, the 48
//   steps and one fold, then the digest words go out one word a cycle as taken.
//   Reset loads the initial vector and clears counts; the memory is not cleared.
module md4_hash_engine_unit (
  input logic   clk_i,
  input logic   rst_ni,
  md4_in_if.sink    in_i,
  md4_out_if.source out_o
);
  import md4_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PADW  = 3'd1;  // write padding words into shadow
  localparam logic [2:0] ST_RUN   = 3'd2;  // compression steps
  localparam logic [2:0] ST_ADD   = 3'd3;  // fold into chaining words
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // word memory: entries 0..15 live block, 16..31 padding scratch
  logic [31:0] mem [32];
  logic [31:0] rd_q;
  logic [4:0]  rd_addr;
  logic        wr_en;
  logic [4:0]  wr_addr;
  logic [31:0] wr_data;

  logic [2:0]  st_q, st_d;
  logic [31:0] h_q [4];       // running chain
  logic [31:0] f_q [4];       // finish copy
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [31:0] part_q;        // bytes of the word in progress
  logic [5:0]  step_q;        // step counter; value 48 means read pending done
  logic        fin_q;         // compressing for finish
  logic        two_q;         // finish needs two blocks
  logic        second_q;      // working on the second finish block
  logic [4:0]  pw_q;          // padding word index
  logic [1:0]  oi_q;

  logic acc_in;
  assign in_i.ready = (st_q == ST_IDLE);
  assign acc_in = in_i.valid && in_i.ready;

  // padding word value for word index w of a finish block
  function automatic logic [31:0] pad_word(input logic [3:0] w, input logic sec,
                                           input logic two, input logic [5:0] n,
                                           input logic [31:0] part, input logic [63:0] len);
    logic [31:0] v;
    logic [3:0]  nw;
    begin
      nw = n[5:2];
      v = 32'd0;
      if (!sec) begin
        if (w == nw) begin
          case (n[1:0])
            2'd0:    v = {24'd0, PAD_MARK};
            2'd1:    v = {16'd0, PAD_MARK, part[7:0]};
            2'd2:    v = {8'd0, PAD_MARK, part[15:0]};
            default: v = {PAD_MARK, part[23:0]};
          endcase
        end
      end
      if (!two || sec) begin
        if (w == 4'd14) v = len[31:0];
        if (w == 4'd15) v = len[63:32];
      end
      pad_word = v;
    end
  endfunction

  // read address: live words below fill, scratch otherwise during finish
  logic [3:0] sel_w;
  logic       live_w;
  assign sel_w  = word_sel(step_q);
  assign live_w = !fin_q || (!second_q && (sel_w < fill_q[5:2]));
  assign rd_addr = {!live_w, sel_w};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // step datapath
  logic [31:0] fx, kx, sum, rot;
  logic [4:0]  sh;
  logic [5:0]  cur;
  assign cur = step_q - 6'd1;
  always_comb begin
    case (cur[5:4])
      2'd0:    begin fx = (b_q & c_q) | (~b_q & d_q); kx = 32'd0; end
      2'd1:    begin fx = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); kx = K_ROUND2; end
      default: begin fx = b_q ^ c_q ^ d_q; kx = K_ROUND3; end
    endcase
    sh  = rot_amt(cur);
    sum = a_q + fx + rd_q + kx;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    if (acc_in && in_i.kind == KIND_ABSORB && fill_q[1:0] == 2'd3) begin
      wr_en = 1'b1; wr_addr = {1'b0, fill_q[5:2]};
      wr_data = {in_i.data_byte, part_q[23:0]};
    end else if (st_q == ST_PADW) begin
      wr_en = 1'b1; wr_addr = {1'b1, pw_q[3:0]};
      wr_data = pad_word(pw_q[3:0], second_q, two_q, fill_q, part_q, len_q);
    end
  end

  logic [31:0] base [4];
  always_comb begin
    for (int k = 0; k < 4; k++) base[k] = fin_q ? f_q[k] : h_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; fill_q <= '0; len_q <= '0;
      h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
      step_q <= '0; fin_q <= 1'b0; two_q <= 1'b0; second_q <= 1'b0;
      pw_q <= '0; oi_q <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (acc_in) begin
            case (in_i.kind)
              KIND_ABSORB: begin
                fill_q <= fill_q + 6'd1;
                len_q  <= len_q + 64'd8;
                if (fill_q == 6'd63) begin
                  // hold for compression
                  fin_q <= 1'b0; step_q <= '0; st_q <= ST_RUN;
                end
              end
              KIND_FINISH: begin
                fin_q <= 1'b1; second_q <= 1'b0;
                two_q <= (fill_q > 6'd55);
                f_q <= h_q; pw_q <= '0; st_q <= ST_PADW;
              end
              KIND_RESTART: begin
                h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
                fill_q <= '0; len_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_PADW: begin
          pw_q <= pw_q + 5'd1;
          if (pw_q == 5'd15) begin step_q <= '0; st_q <= ST_RUN; end
        end
        ST_RUN: begin
          if (step_q == 6'd0) begin
            a_q <= base[0]; b_q <= base[1]; c_q <= base[2]; d_q <= base[3];
          end else begin
            a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= rot;
          end
          step_q <= step_q + 6'd1;
          if (step_q == 6'd48) st_q <= ST_ADD;
        end
        ST_ADD: begin
          if (!fin_q) begin
            h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
            h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
            st_q <= ST_IDLE;
          end else begin
            f_q[0] <= f_q[0] + a_q; f_q[1] <= f_q[1] + b_q;
            f_q[2] <= f_q[2] + c_q; f_q[3] <= f_q[3] + d_q;
            if (two_q && !second_q) begin
              second_q <= 1'b1; pw_q <= '0; st_q <= ST_PADW;
            end else begin
              oi_q <= '0; st_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_o.ready) begin
            oi_q <= oi_q + 2'd1;
            if (oi_q == 2'd3) begin fin_q <= 1'b0; st_q <= ST_IDLE; end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // assemble partial word bytes
  always_ff @(posedge clk_i) begin
    if (acc_in && in_i.kind == KIND_ABSORB) begin
      case (fill_q[1:0])
        2'd0:    part_q[7:0]   <= in_i.data_byte;
        2'd1:    part_q[15:8]  <= in_i.data_byte;
        2'd2:    part_q[23:16] <= in_i.data_byte;
        default: part_q[31:24] <= in_i.data_byte;
      endcase
    end
  end

  assign out_o.valid       = (st_q == ST_EMIT);
  assign out_o.digest_word = f_q[oi_q];
  assign out_o.word_index  = oi_q;
  assign out_o.last        = (oi_q == 2'd3);

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !in_i.ready) else $error("input taken while busy");
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> (step_q <= 6'd48)) else $error("step overrun");
  a_emit_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> fin_q) else $error("emit outside finish");
endmodule
